// File: sv/aabb_pkg.sv
// Shared types and constants for the transformed bounding box block.
// No dependencies; imported by aabb_affine_transform and tb_top.
package aabb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int REG_W         = 64;
  localparam int NUM_REGS      = 6;
  localparam int NUM_AXES      = 3;
  localparam int REG_IDX_W     = 3;

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic [REG_W-1:0]         cfg_word_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW_X_01 = 3'd0,
    REG_ROW_X_23 = 3'd1,
    REG_ROW_Y_01 = 3'd2,
    REG_ROW_Y_23 = 3'd3,
    REG_ROW_Z_01 = 3'd4,
    REG_ROW_Z_23 = 3'd5
  } reg_idx_t;

endpackage

// File: sv/aabb_affine_transform.sv
// Top level of the transformed axis-aligned bounding box block.
// Depends on aabb_pkg for widths, register indexes and types.
//
// One box enters per clock: an item is taken at each rising edge where start
// is high and busy is low, and its bounding box leaves the last stage with
// done high, shown for one cycle. The receiver cannot hold results off, so
// done must be consumed when it appears; there is no back-pressure. Busy is
// high while reset is held and in the cycle after it, and low afterwards,
// so the block sustains one item per cycle through its five register
// stages: corner formation, the eighteen 32x33 multiplies, the floor and
// per-axis min/max selection, the row sums with translation, and the extent
// subtraction with 32-bit saturation. Because the affine map is separable
// per axis, the minimum over the eight corners is the sum of the per-axis
// minima of the two candidate products, so only two corner values per axis
// are ever multiplied. The matrix is written through the cfg port (index 0
// to 5, six 64-bit words, out-of-range indexes ignored) and must only be
// changed when no item is in flight. After reset the matrix is the identity
// with zero translation.
module aabb_affine_transform
  import aabb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   pos_z,
  input  logic signed [31:0]   dim_x,
  input  logic signed [31:0]   dim_y,
  input  logic signed [31:0]   dim_z,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output logic                 done,
  output logic signed [31:0]   min_x,
  output logic signed [31:0]   min_y,
  output logic signed [31:0]   min_z,
  output logic signed [31:0]   size_x,
  output logic signed [31:0]   size_y,
  output logic signed [31:0]   size_z
);

  // Corner coordinates are 33 bits, products 65 bits. After the floor shift
  // a term needs PW bits; three terms plus a translation and the final
  // difference need SW bits.
  localparam int CW = DATA_W + 1;
  localparam int MW = DATA_W + CW;
  localparam int PW = MW - FRAC_BITS;
  localparam int SW = PW + 3;

  localparam logic signed [SW-1:0] SAT_HI = SW'($signed(32'h7fff_ffff));
  localparam logic signed [SW-1:0] SAT_LO = SW'($signed(32'h8000_0000));

  // The value 1.0 in the fixed-point format, used for the identity reset.
  localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;

  logic in_acc;
  logic cfg_acc;

  cfg_word_t regs [NUM_REGS];

  fix_t coef  [NUM_AXES][NUM_AXES];
  fix_t trans [NUM_AXES];

  fix_t pos_in [NUM_AXES];
  fix_t dim_in [NUM_AXES];

  // Stage registers with their valid bits.
  logic v1, v2, v3, v4, v5;
  logic signed [CW-1:0] cor_a [NUM_AXES];
  logic signed [CW-1:0] cor_b [NUM_AXES];
  logic signed [MW-1:0] prod_a [NUM_AXES][NUM_AXES];
  logic signed [MW-1:0] prod_b [NUM_AXES][NUM_AXES];
  logic signed [PW-1:0] term_lo [NUM_AXES][NUM_AXES];
  logic signed [PW-1:0] term_hi [NUM_AXES][NUM_AXES];
  logic signed [SW-1:0] sum_lo [NUM_AXES];
  logic signed [SW-1:0] sum_hi [NUM_AXES];
  fix_t out_min  [NUM_AXES];
  fix_t out_size [NUM_AXES];

  logic signed [SW-1:0] diff_next [NUM_AXES];
  fix_t min_next  [NUM_AXES];
  fix_t size_next [NUM_AXES];

  // Busy covers reset and the cycle after it; the pipeline never stalls.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign in_acc    = start && !busy;
  assign cfg_ready = !busy;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // Matrix registers, reset to the identity.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_ROW_X_01] <= {32'h0, FX_ONE};
      regs[REG_ROW_X_23] <= '0;
      regs[REG_ROW_Y_01] <= {FX_ONE, 32'h0};
      regs[REG_ROW_Y_23] <= '0;
      regs[REG_ROW_Z_01] <= '0;
      regs[REG_ROW_Z_23] <= {32'h0, FX_ONE};
    end else if (cfg_acc) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ROW_X_01: regs[REG_ROW_X_01] <= cfg_data;
        REG_ROW_X_23: regs[REG_ROW_X_23] <= cfg_data;
        REG_ROW_Y_01: regs[REG_ROW_Y_01] <= cfg_data;
        REG_ROW_Y_23: regs[REG_ROW_Y_23] <= cfg_data;
        REG_ROW_Z_01: regs[REG_ROW_Z_01] <= cfg_data;
        REG_ROW_Z_23: regs[REG_ROW_Z_23] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack each row into its three coefficients and its translation.
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      coef[r][0] = fix_t'(regs[2*r][31:0]);
      coef[r][1] = fix_t'(regs[2*r][63:32]);
      coef[r][2] = fix_t'(regs[2*r+1][31:0]);
      trans[r]   = fix_t'(regs[2*r+1][63:32]);
    end
  end

  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;
  assign dim_in[0] = dim_x;
  assign dim_in[1] = dim_y;
  assign dim_in[2] = dim_z;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_acc;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage 1: the two corner coordinates of each axis, pos and pos + dim.
  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      cor_a[a] <= CW'(pos_in[a]);
      cor_b[a] <= CW'(pos_in[a]) + CW'(dim_in[a]);
    end
  end

  // Stage 2: full-precision products of every coefficient with both corners.
  always_ff @(posedge clk) begin
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod_a[r][a] <= MW'(coef[r][a]) * MW'(cor_a[a]);
        prod_b[r][a] <= MW'(coef[r][a]) * MW'(cor_b[a]);
      end
    end
  end

  // Stage 3: floor each product and keep the smaller and larger term.
  // Flooring is monotonic, so ordering the floored terms is exact.
  always_ff @(posedge clk) begin
    logic signed [MW-1:0] sh_a;
    logic signed [MW-1:0] sh_b;
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        sh_a = prod_a[r][a] >>> FRAC_BITS;
        sh_b = prod_b[r][a] >>> FRAC_BITS;
        if (sh_a < sh_b) begin
          term_lo[r][a] <= sh_a[PW-1:0];
          term_hi[r][a] <= sh_b[PW-1:0];
        end else begin
          term_lo[r][a] <= sh_b[PW-1:0];
          term_hi[r][a] <= sh_a[PW-1:0];
        end
      end
    end
  end

  // Stage 4: row sums of the minimum and maximum terms plus translation.
  always_ff @(posedge clk) begin
    for (int r = 0; r < NUM_AXES; r++) begin
      sum_lo[r] <= SW'(term_lo[r][0]) + SW'(term_lo[r][1]) + SW'(term_lo[r][2])
                 + SW'(trans[r]);
      sum_hi[r] <= SW'(term_hi[r][0]) + SW'(term_hi[r][1]) + SW'(term_hi[r][2])
                 + SW'(trans[r]);
    end
  end

  // Stage 5: extent and saturation of both results.
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      diff_next[r] = sum_hi[r] - sum_lo[r];
      if (sum_lo[r] > SAT_HI) begin
        min_next[r] = SAT_HI[DATA_W-1:0];
      end else if (sum_lo[r] < SAT_LO) begin
        min_next[r] = SAT_LO[DATA_W-1:0];
      end else begin
        min_next[r] = sum_lo[r][DATA_W-1:0];
      end
      if (diff_next[r] > SAT_HI) begin
        size_next[r] = SAT_HI[DATA_W-1:0];
      end else if (diff_next[r] < SAT_LO) begin
        size_next[r] = SAT_LO[DATA_W-1:0];
      end else begin
        size_next[r] = diff_next[r][DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < NUM_AXES; r++) begin
      out_min[r]  <= min_next[r];
      out_size[r] <= size_next[r];
    end
  end

  assign done   = v5;
  assign min_x  = out_min[0];
  assign min_y  = out_min[1];
  assign min_z  = out_min[2];
  assign size_x = out_size[0];
  assign size_y = out_size[1];
  assign size_z = out_size[2];

  // Every accepted item produces its result with done high.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> ##5 done)
    else $error("accepted item did not complete after five cycles");

  // A result is only shown for an item that was accepted.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    v5 && !$past(rst, 5) && !$past(rst, 4) && !$past(rst, 3) && !$past(rst, 2)
      && !$past(rst, 1) |-> $past(in_acc, 5))
    else $error("result strobe without a matching accepted item");

  // The selected minimum term never exceeds the selected maximum term (checked on the diagonal terms).
  a_term_order: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (term_lo[0][0] <= term_hi[0][0]) && (term_lo[1][1] <= term_hi[1][1])
           && (term_lo[2][2] <= term_hi[2][2]))
    else $error("min/max term selection out of order");

  // Extents are never negative once saturated.
  a_size_nonneg: assert property (@(posedge clk) disable iff (rst)
    done |-> !size_x[31] && !size_y[31] && !size_z[31])
    else $error("negative extent at the output");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for aabb_affine_transform: boxes in, bounding boxes out.
// Depends on aabb_pkg and the block's RTL only; it predicts every result itself
// and reads no files.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aabb_pkg::*;

  // One box as it is driven onto the payload ports, and one bounding box as it
  // leaves the block. The field order follows the port list.
  typedef struct packed {
    fix_t pos_x, pos_y, pos_z;
    fix_t dim_x, dim_y, dim_z;
  } box_t;

  typedef struct packed {
    fix_t min_x, min_y, min_z;
    fix_t size_x, size_y, size_z;
  } bounds_t;

  // Kinds of matrix that the phases load. The extreme ones push most row sums
  // into saturation; the moderate and fractional ones keep most results in
  // range, so that the floor of each product is what gets checked.
  typedef enum int {
    MAT_MODERATE,
    MAT_FULL,
    MAT_FRACTION,
    MAT_MOST_NEG,
    MAT_ZERO,
    MAT_MOST_POS,
    MAT_MIRROR
  } matrix_style_t;

  localparam int FRAC_BITS       = FRAC_BITS_DEF;
  localparam int LATENCY         = 5;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int NUM_PHASES      = 8;
  localparam int MAX_REPORTS     = 10;
  localparam int DRAIN_LIMIT     = 500;

  localparam fix_t FIX_MAX       = 32'sh7fff_ffff;
  localparam fix_t FIX_MIN       = 32'sh8000_0000;
  localparam fix_t FIX_ZERO      = 32'sh0000_0000;
  localparam fix_t FIX_ONE       = 32'sh0001_0000;
  localparam fix_t FIX_TWO       = 32'sh0002_0000;
  localparam fix_t FIX_MINUS_ONE = 32'shffff_0000;
  localparam fix_t FIX_LSB       = 32'sh0000_0001;
  localparam fix_t FIX_NEG_LSB   = 32'shffff_ffff;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  box_t                 cur_box   = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  cfg_word_t            cfg_data  = '0;
  logic                 done;
  fix_t                 res_min_x, res_min_y, res_min_z;
  fix_t                 res_size_x, res_size_y, res_size_z;

  // Our own copy of the six matrix words, updated on every accepted write to an index in the list.
  cfg_word_t matrix_regs[NUM_REGS];

  box_t    pending_boxes[$];
  bounds_t expected_bounds[$];
  bounds_t seen_bounds, due_bounds;
  int      send_idle_pct = 0;
  int      fault_count   = 0;

  aabb_affine_transform #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .pos_x    (cur_box.pos_x),
    .pos_y    (cur_box.pos_y),
    .pos_z    (cur_box.pos_z),
    .dim_x    (cur_box.dim_x),
    .dim_y    (cur_box.dim_y),
    .dim_z    (cur_box.dim_z),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .done     (done),
    .min_x    (res_min_x),
    .min_y    (res_min_y),
    .min_z    (res_min_z),
    .size_x   (res_size_x),
    .size_y   (res_size_y),
    .size_z   (res_size_z)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Coefficient or translation of one matrix row. Columns 0 and 1 share the
  // first word of the row, column 2 and the translation share the second; the
  // lower column always sits in the low half.
  function automatic fix_t matrix_coef(int row, int col);
    cfg_word_t word;
    word = matrix_regs[2 * row + col / 2];
    return (col % 2 == 1) ? fix_t'(word[2*DATA_W-1:DATA_W]) : fix_t'(word[DATA_W-1:0]);
  endfunction

  // The full product of a 32-bit coefficient and a 33-bit corner coordinate
  // needs 65 bits; an arithmetic shift of it is exactly the floor.
  function automatic longint floor_mul(fix_t coef, logic signed [32:0] coord);
    logic signed [64:0] wide_coef, wide_coord, product;
    wide_coef  = coef;
    wide_coord = coord;
    product    = wide_coef * wide_coord;
    return longint'(product >>> FRAC_BITS);
  endfunction

  function automatic fix_t saturate(longint v);
    if (v > longint'(FIX_MAX)) return FIX_MAX;
    if (v < longint'(FIX_MIN)) return FIX_MIN;
    return fix_t'(v);
  endfunction

  // Maps all eight corners through the matrix and bounds them. The block is
  // free to exploit the separability of the map; here every corner is visited
  // so that the two approaches are genuinely independent.
  function automatic bounds_t transform_box(box_t b);
    fix_t               pos[NUM_AXES];
    fix_t               dim[NUM_AXES];
    logic signed [32:0] coord[NUM_AXES];
    longint             lo[NUM_AXES];
    longint             hi[NUM_AXES];
    longint             sum;
    bounds_t            bounds;
    pos[0] = b.pos_x;
    pos[1] = b.pos_y;
    pos[2] = b.pos_z;
    dim[0] = b.dim_x;
    dim[1] = b.dim_y;
    dim[2] = b.dim_z;
    for (int k = 0; k < 8; k++) begin
      // Bit a of the corner number says whether the extent is added on axis a.
      // A negative extent simply puts that corner below the stated position.
      for (int a = 0; a < NUM_AXES; a++) begin
        coord[a] = pos[a];
        if (k[a]) coord[a] = coord[a] + dim[a];
      end
      for (int row = 0; row < NUM_AXES; row++) begin
        sum = floor_mul(matrix_coef(row, 0), coord[0])
            + floor_mul(matrix_coef(row, 1), coord[1])
            + floor_mul(matrix_coef(row, 2), coord[2])
            + longint'(matrix_coef(row, 3));
        if (k == 0 || sum < lo[row]) lo[row] = sum;
        if (k == 0 || sum > hi[row]) hi[row] = sum;
      end
    end
    // The minimum and the extent are each formed wide and only then saturated.
    bounds.min_x  = saturate(lo[0]);
    bounds.min_y  = saturate(lo[1]);
    bounds.min_z  = saturate(lo[2]);
    bounds.size_x = saturate(hi[0] - lo[0]);
    bounds.size_y = saturate(hi[1] - lo[1]);
    bounds.size_z = saturate(hi[2] - lo[2]);
    return bounds;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Uniform signed value in [-2^bits, 2^bits - 1].
  function automatic fix_t rand_fix(int bits);
    return fix_t'(int'($urandom_range(0, (2 << bits) - 1)) - (1 << bits));
  endfunction

  function automatic fix_t boundary_value();
    case ($urandom_range(5))
      0:       return FIX_MAX;
      1:       return FIX_MIN;
      2:       return FIX_ZERO;
      3:       return FIX_LSB;
      4:       return FIX_NEG_LSB;
      default: return FIX_ONE;
    endcase
  endfunction

  // Most boxes are moderate, so that the results stay in range and the floor
  // arithmetic is visible; a quarter use the full 32-bit range of every field
  // and the rest are built from boundary values.
  function automatic box_t random_box();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) begin
      return '{rand_fix(23), rand_fix(23), rand_fix(23),
               rand_fix(20), rand_fix(20), rand_fix(20)};
    end else if (sel < 85) begin
      return '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      return '{boundary_value(), boundary_value(), boundary_value(),
               boundary_value(), boundary_value(), boundary_value()};
    end
  endfunction

  function automatic box_t make_box(fix_t px, fix_t py, fix_t pz,
                                    fix_t dx, fix_t dy, fix_t dz);
    return '{px, py, pz, dx, dy, dz};
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: when the previous item has been taken or nothing is on offer, it
  // offers the next pending item or idles at random. Idle, it puts noise on
  // the payload, which the block must ignore. Each signal is assigned once per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_bounds.push_back(transform_box(cur_box));
      end
      if (!start || !busy) begin
        if (pending_boxes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          start   <= 1'b1;
          cur_box <= pending_boxes.pop_front();
        end else begin
          start   <= 1'b0;
          cur_box <= random_box();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every done pulse is one result, checked against the oldest
  // prediction field by field.
  // ---------------------------------------------------------------------------
  task automatic note_fault(string msg);
    if (fault_count < MAX_REPORTS) $display("%0t ns: %s", $time, msg);
    fault_count++;
  endtask

  task automatic check_field(string name, fix_t want, fix_t got);
    if (got !== want) begin
      note_fault($sformatf("%s mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                           name, want, want, got, got));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      seen_bounds = '{res_min_x, res_min_y, res_min_z,
                      res_size_x, res_size_y, res_size_z};
      if (expected_bounds.size() == 0) begin
        note_fault("result arrived with no item outstanding");
      end else begin
        due_bounds = expected_bounds.pop_front();
        check_field("min_x",  due_bounds.min_x,  seen_bounds.min_x);
        check_field("min_y",  due_bounds.min_y,  seen_bounds.min_y);
        check_field("min_z",  due_bounds.min_z,  seen_bounds.min_z);
        check_field("size_x", due_bounds.size_x, seen_bounds.size_x);
        check_field("size_y", due_bounds.size_y, seen_bounds.size_y);
        check_field("size_z", due_bounds.size_z, seen_bounds.size_z);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration and sequencing
  // ---------------------------------------------------------------------------

  // One register write. It is entered at a rising edge and leaves cfg_valid
  // high on return, so that back-to-back writes never lower and raise it in
  // the same step; the caller drops it after the last write.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, cfg_word_t word);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
    // Indexes past the register list are ignored by the block.
    if (idx < NUM_REGS) matrix_regs[idx] = word;
  endtask

  task automatic load_matrix(matrix_style_t style);
    cfg_word_t words[NUM_REGS];
    reg_idx_t  idx;
    fix_t      value;
    logic      is_trans;
    for (int row = 0; row < NUM_AXES; row++) begin
      for (int col = 0; col <= NUM_AXES; col++) begin
        is_trans = (col == NUM_AXES);
        case (style)
          MAT_MODERATE: value = is_trans ? rand_fix(24) : rand_fix(18);
          MAT_FULL:     value = fix_t'($urandom);
          MAT_FRACTION: value = is_trans ? rand_fix(20) : rand_fix(16);
          MAT_MOST_NEG: value = is_trans ? FIX_MAX : FIX_MIN;
          MAT_MOST_POS: value = is_trans ? FIX_MIN : FIX_MAX;
          MAT_ZERO:     value = FIX_ZERO;
          default: begin
            // A mirror through the origin, then a shift.
            if (is_trans) value = rand_fix(20);
            else          value = (row == col) ? FIX_MINUS_ONE : FIX_ZERO;
          end
        endcase
        words[2 * row + col / 2][(col % 2) * DATA_W +: DATA_W] = value;
      end
    end
    // A write to an index beyond the list first; it must change nothing.
    write_reg(REG_IDX_W'(NUM_REGS + $urandom_range(1)), {$urandom, $urandom});
    idx = idx.first();
    repeat (NUM_REGS) begin
      write_reg(idx, words[idx]);
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_accepted();
    do @(posedge clk); while (pending_boxes.size() != 0 || start);
  endtask

  // The block never holds results back, so this normally returns once the
  // last result is in; the guard only stops a hang.
  task automatic wait_results();
    for (int guard = 0; guard < DRAIN_LIMIT && expected_bounds.size() != 0; guard++)
      @(posedge clk);
  endtask

  initial begin
    matrix_style_t plan[NUM_PHASES];
    plan = '{MAT_MODERATE, MAT_FULL, MAT_FRACTION, MAT_MOST_NEG,
             MAT_ZERO, MAT_MOST_POS, MAT_MIRROR, MAT_MODERATE};

    // After reset the block holds the identity with no translation.
    foreach (matrix_regs[i]) matrix_regs[i] = '0;
    matrix_regs[REG_ROW_X_01] = {FIX_ZERO, FIX_ONE};
    matrix_regs[REG_ROW_Y_01] = {FIX_ONE, FIX_ZERO};
    matrix_regs[REG_ROW_Z_23] = {FIX_ZERO, FIX_ONE};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed boxes under the reset matrix: zero and unit boxes, negative
    // extents, the extremes of every field, and sums that overflow 32 bits in
    // either direction so that the minimum and the extent both saturate.
    send_idle_pct = 18;
    pending_boxes.push_back(make_box(FIX_ZERO, FIX_ZERO, FIX_ZERO,
                                     FIX_ZERO, FIX_ZERO, FIX_ZERO));
    pending_boxes.push_back(make_box(FIX_ZERO, FIX_ZERO, FIX_ZERO,
                                     FIX_ONE, FIX_ONE, FIX_ONE));
    pending_boxes.push_back(make_box(FIX_ONE, FIX_TWO, FIX_MINUS_ONE,
                                     FIX_MINUS_ONE, FIX_MINUS_ONE, FIX_MINUS_ONE));
    pending_boxes.push_back(make_box(FIX_MAX, FIX_MAX, FIX_MAX,
                                     FIX_ZERO, FIX_ZERO, FIX_ZERO));
    pending_boxes.push_back(make_box(FIX_MIN, FIX_MIN, FIX_MIN,
                                     FIX_ZERO, FIX_ZERO, FIX_ZERO));
    pending_boxes.push_back(make_box(FIX_MAX, FIX_MAX, FIX_MAX,
                                     FIX_MAX, FIX_MAX, FIX_MAX));
    pending_boxes.push_back(make_box(FIX_MIN, FIX_MIN, FIX_MIN,
                                     FIX_MIN, FIX_MIN, FIX_MIN));
    pending_boxes.push_back(make_box(FIX_MAX, FIX_MAX, FIX_MAX,
                                     FIX_MIN, FIX_MIN, FIX_MIN));
    pending_boxes.push_back(make_box(FIX_MIN, FIX_MIN, FIX_MIN,
                                     FIX_MAX, FIX_MAX, FIX_MAX));
    pending_boxes.push_back(make_box(FIX_NEG_LSB, FIX_NEG_LSB, FIX_NEG_LSB,
                                     FIX_LSB, FIX_LSB, FIX_LSB));
    pending_boxes.push_back(make_box(FIX_LSB, FIX_LSB, FIX_LSB,
                                     FIX_NEG_LSB, FIX_NEG_LSB, FIX_NEG_LSB));
    pending_boxes.push_back(make_box(FIX_MAX, FIX_MIN, FIX_ZERO,
                                     FIX_MIN, FIX_MAX, FIX_NEG_LSB));
    wait_accepted();
    wait_results();

    // Random phases, each under a freshly loaded matrix. The sender idles
    // lightly at first, then heavily, and finally not at all.
    for (int p = 0; p < NUM_PHASES; p++) begin
      load_matrix(plan[p]);
      send_idle_pct = (p < 3) ? 18 : (p < 6) ? 53 : 0;
      repeat (ITEMS_PER_PHASE) pending_boxes.push_back(random_box());
      wait_accepted();
      wait_results();
    end

    // Let any late or spurious result show itself before judging.
    repeat (LATENCY + 3) @(posedge clk);
    if (expected_bounds.size() != 0)
      note_fault($sformatf("%0d results never arrived", expected_bounds.size()));

    if (fault_count == 0) begin
      $display("** aabb_affine_transform: PASSED **");
    end else begin
      $display("** aabb_affine_transform: FAILED **");
    end
    $finish;
  end

  // Watchdog: a correct run takes well under a tenth of this.
  initial begin
    #2_000_000;
    $display("** aabb_affine_transform: FAILED **");
    $finish;
  end

endmodule
